// ----- rtl/pgcbf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgcbf_pkg: shared types and constants of the per-gate biquad cascade
// Field widths, fixed-point formats, coefficient and history word layouts,
// and the register index codes of the configuration port.
// ----------------------------------------------------------------------------
package pgcbf_pkg;

  // Gate count and the history store depth derived from it.
  localparam int MAX_GATES = 1024;
  localparam int SLOTS     = 2 * MAX_GATES;
  localparam int ADDR_W    = $clog2(SLOTS);

  // Field and arithmetic widths.
  localparam int SLOT_W = 11;
  localparam int SAMP_W = 16;
  localparam int COEF_W = 18;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 54;
  localparam int FF_W   = 3 * COEF_W;
  localparam int FB_W   = 2 * COEF_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = FF_W;

  // Result queue that decouples the pipeline from the output handshake.
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Register index codes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_S1_FF = 3'd0,
    CFG_S1_FB = 3'd1,
    CFG_S2_FF = 3'd2,
    CFG_S2_FB = 3'd3
  } cfg_idx_t;

  // Coefficients of both sections, signed Q2.16.
  typedef struct packed {
    logic signed [COEF_W-1:0] s1_b0;
    logic signed [COEF_W-1:0] s1_b1;
    logic signed [COEF_W-1:0] s1_b2;
    logic signed [COEF_W-1:0] s1_a1;
    logic signed [COEF_W-1:0] s1_a2;
    logic signed [COEF_W-1:0] s2_b0;
    logic signed [COEF_W-1:0] s2_b1;
    logic signed [COEF_W-1:0] s2_b2;
    logic signed [COEF_W-1:0] s2_a1;
    logic signed [COEF_W-1:0] s2_a2;
  } coef_t;

  // One history word per slot; x1 sits in the lowest bits.
  typedef struct packed {
    logic signed [VAL_W-1:0]  q2;
    logic signed [VAL_W-1:0]  q1;
    logic signed [VAL_W-1:0]  p2;
    logic signed [VAL_W-1:0]  p1;
    logic signed [SAMP_W-1:0] x2;
    logic signed [SAMP_W-1:0] x1;
  } hist_t;

  // One result beat.
  typedef struct packed {
    logic [SLOT_W-1:0]        slot;
    logic signed [SAMP_W-1:0] filtered;
    logic                     saturated;
  } res_t;

  // Status from the datapath to the input handshake.
  typedef struct packed {
    logic clearing;
    logic hazard;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/per_gate_cascaded_biquad_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// per_gate_cascaded_biquad_filter: per-slot two-section biquad cascade
// Top level: input handshake, result credit, coefficient port and output.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock while it does not stall, and
// returns one result beat per sample, in order. The rate is set by the
// history memory's single read-modify-write per beat: a beat for a slot that
// is still in the pipeline is held until that slot's history is written back
// in stage six, while beats for different slots flow at one per cycle as
// long as the result queue has room. A sixteen-entry result queue lets the
// block keep accepting while results wait to be taken. After reset the
// history memory is cleared in one pass, during which no sample is
// accepted; coefficient writes are taken at any time.
// ----------------------------------------------------------------------------
module per_gate_cascaded_biquad_filter
  import pgcbf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [SLOT_W-1:0]        in_slot,
  input  wire logic signed [SAMP_W-1:0] in_sample,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [SLOT_W-1:0]             out_slot,
  output logic signed [SAMP_W-1:0]      out_filtered,
  output logic                          out_saturated,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  coef_t            coef;
  dp_status_t       dp_status;
  logic             in_accept;
  logic             out_accept;
  logic             res_valid;
  res_t             res;
  res_t             head;
  logic [CNT_W-1:0] credit_r;
  logic             credit_full;

  // Coefficient registers; writes are always taken.
  assign cfg_ready = 1'b1;

  pgcbf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef     (coef)
  );

  // Beats in flight plus beats queued never exceed the queue depth.
  assign credit_full = (credit_r == CNT_W'(FIFO_DEPTH));
  assign in_stall    = dp_status.clearing || dp_status.hazard || credit_full;
  assign in_accept   = in_valid && !in_stall;
  assign out_accept  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      unique case ({in_accept, out_accept})
        2'b10:   credit_r <= credit_r + CNT_W'(1);
        2'b01:   credit_r <= credit_r - CNT_W'(1);
        default: credit_r <= credit_r;
      endcase
    end
  end

  // Filter pipeline around the history memory.
  pgcbf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef),
    .accept    (in_accept),
    .in_slot   (in_slot),
    .in_sample (in_sample),
    .status    (dp_status),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue in front of the output port.
  pgcbf_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .pop        (out_accept),
    .head_valid (out_valid),
    .head       (head)
  );

  assign out_slot      = head.slot;
  assign out_filtered  = head.filtered;
  assign out_saturated = head.saturated;

endmodule
`default_nettype wire

// ----- rtl/pgcbf_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgcbf_cfg_regs: coefficient registers
// Holds the four packed coefficient registers and presents them unpacked.
// ----------------------------------------------------------------------------
module pgcbf_cfg_regs
  import pgcbf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output coef_t                      coef
);

  logic [FF_W-1:0] s1_ff_r;
  logic [FB_W-1:0] s1_fb_r;
  logic [FF_W-1:0] s2_ff_r;
  logic [FB_W-1:0] s2_fb_r;

  // Register writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ff_r <= FF_W'(65536);
      s1_fb_r <= '0;
      s2_ff_r <= FF_W'(65536);
      s2_fb_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_S1_FF: s1_ff_r <= wr_data[FF_W-1:0];
        CFG_S1_FB: s1_fb_r <= wr_data[FB_W-1:0];
        CFG_S2_FF: s2_ff_r <= wr_data[FF_W-1:0];
        CFG_S2_FB: s2_fb_r <= wr_data[FB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the coefficient fields, lowest field first.
  assign coef.s1_b0 = s1_ff_r[COEF_W-1:0];
  assign coef.s1_b1 = s1_ff_r[2*COEF_W-1:COEF_W];
  assign coef.s1_b2 = s1_ff_r[3*COEF_W-1:2*COEF_W];
  assign coef.s1_a1 = s1_fb_r[COEF_W-1:0];
  assign coef.s1_a2 = s1_fb_r[2*COEF_W-1:COEF_W];
  assign coef.s2_b0 = s2_ff_r[COEF_W-1:0];
  assign coef.s2_b1 = s2_ff_r[2*COEF_W-1:COEF_W];
  assign coef.s2_b2 = s2_ff_r[3*COEF_W-1:2*COEF_W];
  assign coef.s2_a1 = s2_fb_r[COEF_W-1:0];
  assign coef.s2_a2 = s2_fb_r[2*COEF_W-1:COEF_W];

endmodule
`default_nettype wire

// ----- rtl/pgcbf_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgcbf_datapath: history memory and filter pipeline
// Reads the slot's history word on accept, runs both sections through a
// seven-stage pipeline and writes the updated history back in stage six.
// A slot whose write-back is still pending blocks a new beat for the same slot.
// ----------------------------------------------------------------------------
module pgcbf_datapath
  import pgcbf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire coef_t                    coef,
  input  wire logic                     accept,
  input  wire logic [SLOT_W-1:0]        in_slot,
  input  wire logic signed [SAMP_W-1:0] in_sample,
  output dp_status_t                    status,
  output logic                          res_valid,
  output res_t                          res
);

  localparam int PROD_S_W = COEF_W + SAMP_W;
  localparam int PROD_Y_W = COEF_W + VAL_W;
  localparam int RND_W    = ACC_W + 1;
  localparam int SHR_W    = RND_W - 16;
  localparam int OUT_W    = VAL_W + 1;
  localparam int OSH_W    = OUT_W - 16;
  localparam logic signed [SHR_W-1:0] SAT_HI  = SHR_W'(64'sd2147483647);
  localparam logic signed [SHR_W-1:0] SAT_LO  = SHR_W'(-64'sd2147483648);
  localparam logic signed [OSH_W-1:0] OSAT_HI = OSH_W'(32767);
  localparam logic signed [OSH_W-1:0] OSAT_LO = OSH_W'(-32768);

  // Values carried to the write-back stage.
  typedef struct packed {
    logic signed [SAMP_W-1:0] samp;
    logic signed [SAMP_W-1:0] x1;
    logic signed [VAL_W-1:0]  p1;
    logic signed [VAL_W-1:0]  q1;
  } carry_t;

  // Round half up to Q16.16 and saturate to 32 bits.
  function automatic logic signed [VAL_W-1:0] rnd_sat32(input logic signed [ACC_W-1:0] a);
    logic signed [RND_W-1:0] sum;
    logic signed [SHR_W-1:0] shr;
    sum = RND_W'(a) + RND_W'(32768);
    shr = sum[RND_W-1:16];
    if (shr > SAT_HI) begin
      rnd_sat32 = SAT_HI[VAL_W-1:0];
    end else if (shr < SAT_LO) begin
      rnd_sat32 = SAT_LO[VAL_W-1:0];
    end else begin
      rnd_sat32 = shr[VAL_W-1:0];
    end
  endfunction

  // Round to an integer and saturate to 16 bits; the top bit flags clipping.
  function automatic logic [SAMP_W:0] rnd_out(input logic signed [VAL_W-1:0] v);
    logic signed [OUT_W-1:0] sum;
    logic signed [OSH_W-1:0] shr;
    sum = OUT_W'(v) + OUT_W'(32768);
    shr = sum[OUT_W-1:16];
    if (shr > OSAT_HI) begin
      rnd_out = {1'b1, OSAT_HI[SAMP_W-1:0]};
    end else if (shr < OSAT_LO) begin
      rnd_out = {1'b1, OSAT_LO[SAMP_W-1:0]};
    end else begin
      rnd_out = {1'b0, shr[SAMP_W-1:0]};
    end
  endfunction

  hist_t                      hist_mem [SLOTS];
  hist_t                      rd_data_r;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  hist_t                      mem_wdata;
  hist_t                      wb_word;

  logic                       clr_busy_r;
  logic [ADDR_W-1:0]          clr_addr_r;

  logic [7:1]                 vld_r;
  logic [7:1]                 inr_r;
  logic [SLOT_W-1:0]          slot_r [1:7];
  logic                       inr_nxt;
  logic                       hazard;

  logic signed [SAMP_W-1:0]   samp1_r;
  logic signed [PROD_S_W-1:0] pb0_r, pb1_r, pb2_r;
  logic signed [PROD_Y_W-1:0] pa1_r, pa2_r, pc1_r, pc2_r, pd1_r, pd2_r;
  carry_t                     car_r [2:6];
  logic signed [ACC_W-1:0]    ff1_sum;
  logic signed [ACC_W-1:0]    acc1_r;
  logic signed [ACC_W-1:0]    part2_3_r, part2_4_r, part2_5_r;
  logic signed [VAL_W-1:0]    y1_4_r, y1_5_r, y1_6_r;
  logic signed [PROD_Y_W-1:0] m_r;
  logic signed [ACC_W-1:0]    acc2_r;
  logic signed [VAL_W-1:0]    y2;
  logic signed [VAL_W-1:0]    y2_r;
  logic [SAMP_W:0]            out_rnd;

  // Slot range check at the input.
  assign inr_nxt = ({1'b0, in_slot} < (SLOT_W + 1)'(SLOTS));

  // Control: valid pipeline and the clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      vld_r <= {vld_r[6:1], accept};
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(SLOTS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // Slot and range flag travel alongside the beat.
  always_ff @(posedge clk) begin
    slot_r[1] <= in_slot;
    inr_r[1]  <= inr_nxt;
    for (int k = 2; k <= 7; k++) begin
      slot_r[k] <= slot_r[k-1];
      inr_r[k]  <= inr_r[k-1];
    end
  end

  // Interlock: a slot read before its pending write-back would see stale history.
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= 6; k++) begin
      if (vld_r[k] && (slot_r[k] == in_slot)) begin
        hazard = 1'b1;
      end
    end
  end

  assign status.clearing = clr_busy_r;
  assign status.hazard   = hazard;

  // History memory: one write port, one registered read port.
  assign wb_word.x1 = car_r[6].samp;
  assign wb_word.x2 = car_r[6].x1;
  assign wb_word.p1 = y1_6_r;
  assign wb_word.p2 = car_r[6].p1;
  assign wb_word.q1 = y2;
  assign wb_word.q2 = car_r[6].q1;

  assign mem_we    = clr_busy_r || (vld_r[6] && inr_r[6]);
  assign mem_waddr = clr_busy_r ? clr_addr_r : slot_r[6][ADDR_W-1:0];
  assign mem_wdata = clr_busy_r ? '0 : wb_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_r <= hist_mem[in_slot[ADDR_W-1:0]];
    end
  end

  // Stage 1: sample register; the history word arrives from memory.
  always_ff @(posedge clk) begin
    samp1_r <= in_sample;
  end

  // Stage 1 to 2: all products that do not depend on this beat's first section.
  always_ff @(posedge clk) begin
    pb0_r <= coef.s1_b0 * samp1_r;
    pb1_r <= coef.s1_b1 * rd_data_r.x1;
    pb2_r <= coef.s1_b2 * rd_data_r.x2;
    pa1_r <= coef.s1_a1 * rd_data_r.p1;
    pa2_r <= coef.s1_a2 * rd_data_r.p2;
    pc1_r <= coef.s2_b1 * rd_data_r.p1;
    pc2_r <= coef.s2_b2 * rd_data_r.p2;
    pd1_r <= coef.s2_a1 * rd_data_r.q1;
    pd2_r <= coef.s2_a2 * rd_data_r.q2;
    car_r[2].samp <= samp1_r;
    car_r[2].x1   <= rd_data_r.x1;
    car_r[2].p1   <= rd_data_r.p1;
    car_r[2].q1   <= rd_data_r.q1;
  end

  // Stage 2 to 3: first section sum and the second section's history terms.
  assign ff1_sum = ACC_W'(pb0_r) + ACC_W'(pb1_r) + ACC_W'(pb2_r);

  always_ff @(posedge clk) begin
    acc1_r    <= (ff1_sum <<< 16) - ACC_W'(pa1_r) - ACC_W'(pa2_r);
    part2_3_r <= ACC_W'(pc1_r) + ACC_W'(pc2_r) - ACC_W'(pd1_r) - ACC_W'(pd2_r);
  end

  // Stage 3 to 4: first section output.
  always_ff @(posedge clk) begin
    y1_4_r    <= rnd_sat32(acc1_r);
    part2_4_r <= part2_3_r;
  end

  // Stage 4 to 5: second section feed-forward product on the new value.
  always_ff @(posedge clk) begin
    m_r       <= coef.s2_b0 * y1_4_r;
    part2_5_r <= part2_4_r;
    y1_5_r    <= y1_4_r;
  end

  // Stage 5 to 6: second section sum.
  always_ff @(posedge clk) begin
    acc2_r <= ACC_W'(m_r) + part2_5_r;
    y1_6_r <= y1_5_r;
  end

  // Carried history values.
  always_ff @(posedge clk) begin
    for (int k = 3; k <= 6; k++) begin
      car_r[k] <= car_r[k-1];
    end
  end

  // Stage 6: second section output, written back to memory.
  assign y2 = rnd_sat32(acc2_r);

  always_ff @(posedge clk) begin
    y2_r <= y2;
  end

  // Stage 7: output rounding and clipping.
  assign out_rnd       = rnd_out(y2_r);
  assign res_valid     = vld_r[7];
  assign res.slot      = slot_r[7];
  assign res.filtered  = inr_r[7] ? out_rnd[SAMP_W-1:0] : '0;
  assign res.saturated = inr_r[7] ? out_rnd[SAMP_W] : 1'b0;

endmodule
`default_nettype wire

// ----- rtl/pgcbf_out_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgcbf_out_fifo: result queue
// Holds finished results until the output side takes them. The head beat
// is shown directly and stays fixed while the output is stalled.
// ----------------------------------------------------------------------------
module pgcbf_out_fifo
  import pgcbf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_data,
  input  wire logic pop,
  output logic      head_valid,
  output res_t      head
);

  res_t               store [FIFO_DEPTH];
  logic [FIFO_AW:0]   wr_ptr_r;
  logic [FIFO_AW:0]   rd_ptr_r;

  // Pointers carry one extra bit to tell full from empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + (FIFO_AW + 1)'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + (FIFO_AW + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r[FIFO_AW-1:0]] <= push_data;
    end
  end

  assign head_valid = (wr_ptr_r != rd_ptr_r);
  assign head       = store[rd_ptr_r[FIFO_AW-1:0]];

endmodule
`default_nettype wire

// ----- rtl/pgcbf_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgcbf_checker: port-level checks of the biquad cascade
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module pgcbf_checker
  import pgcbf_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [SLOT_W-1:0]        out_slot,
  input wire logic signed [SAMP_W-1:0] out_filtered,
  input wire logic                     out_saturated
);

  // A stalled result beat stays offered.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable(out_slot) && $stable(out_filtered) && $stable(out_saturated))
    else $error("result payload changed while stalled");

  // A clipped result sits at one of the range limits.
  a_sat_limit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_filtered == 16'sh7fff) || (out_filtered == 16'sh8000))
    else $error("saturation flag on an unclipped value");

  // The history clearing pass blocks samples straight after reset.
  a_clear_after_reset : assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("sample accepted during the clearing pass");

endmodule

bind per_gate_cascaded_biquad_filter pgcbf_checker u_pgcbf_checker (.*);
`default_nettype wire
